// File: rtl/ipbl_pkg.sv
// Package: shared types and constants of the IPv4 blocklist match table
`default_nettype none
package ipbl_pkg;
    localparam int unsigned EXACT_DEPTH_DEF = 256;
    localparam int unsigned RANGE_DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        KIND_LOOKUP = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_RANGE  = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_EXACT = 2'd1,
        SRC_RANGE = 2'd2
    } src_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } state_t;

    function automatic logic [31:0] prefix_to_mask(input logic [5:0] prefix);
        logic [31:0] m;
        begin
            if (prefix == 6'd0)
                m = 32'd0;
            else if (prefix >= 6'd32)
                m = 32'hFFFF_FFFF;
            else
                m = 32'hFFFF_FFFF << (6'd32 - prefix);
            return m;
        end
    endfunction
endpackage
`default_nettype wire

// File: rtl/ipbl_req_if.sv
// Interfaces: request and result channels of the blocklist table
`default_nettype none
interface ipbl_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] address;
    logic [5:0]  prefix_length;
    modport source (output valid, kind, address, prefix_length, input ready);
    modport sink (input valid, kind, address, prefix_length, output ready);
endinterface

interface ipbl_rsp_if;
    logic        valid;
    logic        ready;
    logic        blocked;
    logic [1:0]  match_source;
    logic [1:0]  status;
    logic [8:0]  exact_count_out;
    logic [4:0]  range_count_out;
    modport source (output valid, blocked, match_source, status, exact_count_out,
                    range_count_out, input ready);
    modport sink (input valid, blocked, match_source, status, exact_count_out,
                  range_count_out, output ready);
endinterface
`default_nettype wire

// File: rtl/ipbl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none
module ipbl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/ipbl_ctrl.sv
// Sequencer: binary search, shift insert/remove, range add, range scan, clear
`default_nettype none
module ipbl_ctrl #(
    parameter int unsigned EXACT_DEPTH = ipbl_pkg::EXACT_DEPTH_DEF,
    parameter int unsigned RANGE_DEPTH = ipbl_pkg::RANGE_DEPTH_DEF,
    localparam int unsigned EAW = (EXACT_DEPTH > 1) ? $clog2(EXACT_DEPTH) : 1,
    localparam int unsigned RAW = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1,
    localparam int unsigned ECW = $clog2(EXACT_DEPTH + 1),
    localparam int unsigned RCW = $clog2(RANGE_DEPTH + 1)
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ipbl_req_if.sink    req,
    ipbl_rsp_if.source  rsp,
    output logic           ex_we,
    output logic [EAW-1:0] ex_waddr,
    output logic [31:0]    ex_wdata,
    output logic [EAW-1:0] ex_raddr,
    input  wire logic [31:0] ex_rdata,
    output logic           rg_we,
    output logic [RAW-1:0] rg_waddr,
    output logic [63:0]    rg_wdata,
    output logic [RAW-1:0] rg_raddr,
    input  wire logic [63:0] rg_rdata
);
    ipbl_pkg::state_t state_reg, state_next;
    logic [2:0]     kind_reg, kind_next;
    logic [31:0]    addr_reg, addr_next;
    logic [5:0]     pfx_reg, pfx_next;
    logic [ECW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [ECW-1:0] idx_reg, idx_next;
    logic [ECW-1:0] ecnt_reg, ecnt_next;
    logic [RCW-1:0] rcnt_reg, rcnt_next;
    logic           found_reg, found_next;
    logic           blk_reg, blk_next;
    logic [1:0]     src_reg, src_next;
    logic [1:0]     st_reg, st_next;

    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipbl_pkg::S_IDLE;
            ecnt_reg  <= '0;
            rcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ecnt_reg  <= ecnt_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        addr_reg  <= addr_next;
        pfx_reg   <= pfx_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        blk_reg   <= blk_next;
        src_reg   <= src_next;
        st_reg    <= st_next;
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        addr_next  = addr_reg;
        pfx_next   = pfx_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        ecnt_next  = ecnt_reg;
        rcnt_next  = rcnt_reg;
        found_next = found_reg;
        blk_next   = blk_reg;
        src_next   = src_reg;
        st_next    = st_reg;
        ex_we      = 1'b0;
        ex_waddr   = idx_reg[EAW-1:0];
        ex_wdata   = addr_reg;
        ex_raddr   = mid[EAW-1:0];
        rg_we      = 1'b0;
        rg_waddr   = rcnt_reg[RAW-1:0];
        rg_wdata   = {ipbl_pkg::prefix_to_mask(pfx_reg),
                      addr_reg & ipbl_pkg::prefix_to_mask(pfx_reg)};
        rg_raddr   = idx_reg[RAW-1:0];
        req.ready  = 1'b0;
        rsp.valid  = 1'b0;
        unique case (state_reg)
            ipbl_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    addr_next  = req.address;
                    pfx_next   = req.prefix_length;
                    lo_next    = '0;
                    hi_next    = ecnt_reg;
                    idx_next   = '0;
                    found_next = 1'b0;
                    blk_next   = 1'b0;
                    src_next   = ipbl_pkg::SRC_NONE;
                    st_next    = ipbl_pkg::ST_OK;
                    case (req.kind) inside
                        ipbl_pkg::KIND_LOOKUP, ipbl_pkg::KIND_ADD,
                        ipbl_pkg::KIND_REMOVE: state_next = ipbl_pkg::S_SRCH_RD;
                        ipbl_pkg::KIND_RANGE: state_next = ipbl_pkg::S_DECIDE;
                        ipbl_pkg::KIND_CLEAR:
                        begin
                            ecnt_next  = '0;
                            rcnt_next  = '0;
                            state_next = ipbl_pkg::S_DONE;
                        end
                        default: state_next = ipbl_pkg::S_DONE;
                    endcase
                end
            end
            ipbl_pkg::S_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                    state_next = ipbl_pkg::S_SRCH_CMP;
                else if (lo_reg < ecnt_reg)
                begin
                    ex_raddr   = lo_reg[EAW-1:0];
                    found_next = 1'b1;
                    state_next = ipbl_pkg::S_DECIDE;
                end
                else
                    state_next = ipbl_pkg::S_DECIDE;
            end
            ipbl_pkg::S_SRCH_CMP:
            begin
                if (ex_rdata < addr_reg)
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
                state_next = ipbl_pkg::S_SRCH_RD;
            end
            ipbl_pkg::S_DECIDE:
            begin
                state_next = ipbl_pkg::S_DONE;
                found_next = found_reg && (ex_rdata == addr_reg);
                case (kind_reg)
                    ipbl_pkg::KIND_LOOKUP:
                        if (found_reg && ex_rdata == addr_reg)
                        begin
                            blk_next = 1'b1;
                            src_next = ipbl_pkg::SRC_EXACT;
                        end
                        else if (rcnt_reg != '0)
                        begin
                            idx_next   = '0;
                            state_next = ipbl_pkg::S_SCAN_RD;
                        end
                    ipbl_pkg::KIND_ADD:
                        if (!(found_reg && ex_rdata == addr_reg))
                        begin
                            if (ecnt_reg >= ECW'(EXACT_DEPTH))
                                st_next = ipbl_pkg::ST_FULL;
                            else
                            begin
                                idx_next   = ecnt_reg;
                                state_next = ipbl_pkg::S_SHIFT_RD;
                            end
                        end
                    ipbl_pkg::KIND_REMOVE:
                        if (found_reg && ex_rdata == addr_reg)
                        begin
                            idx_next   = lo_reg;
                            state_next = ipbl_pkg::S_SHIFT_RD;
                        end
                        else
                            st_next = ipbl_pkg::ST_ABSENT;
                    default:
                        if (rcnt_reg >= RCW'(RANGE_DEPTH))
                            st_next = ipbl_pkg::ST_FULL;
                        else
                        begin
                            rg_we     = 1'b1;
                            rcnt_next = rcnt_reg + 1'b1;
                        end
                endcase
            end
            ipbl_pkg::S_SHIFT_RD:
            begin
                if (kind_reg == ipbl_pkg::KIND_ADD)
                begin
                    if (idx_reg == lo_reg)
                    begin
                        ex_we      = 1'b1;
                        ecnt_next  = ecnt_reg + 1'b1;
                        state_next = ipbl_pkg::S_DONE;
                    end
                    else
                    begin
                        ex_raddr   = EAW'(idx_reg - 1'b1);
                        state_next = ipbl_pkg::S_SHIFT_WR;
                    end
                end
                else
                begin
                    if (idx_reg + 1'b1 >= ecnt_reg)
                    begin
                        ecnt_next  = ecnt_reg - 1'b1;
                        state_next = ipbl_pkg::S_DONE;
                    end
                    else
                    begin
                        ex_raddr   = EAW'(idx_reg + 1'b1);
                        state_next = ipbl_pkg::S_SHIFT_WR;
                    end
                end
            end
            ipbl_pkg::S_SHIFT_WR:
            begin
                ex_we    = 1'b1;
                ex_wdata = ex_rdata;
                if (kind_reg == ipbl_pkg::KIND_ADD)
                    idx_next = idx_reg - 1'b1;
                else
                    idx_next = idx_reg + 1'b1;
                state_next = ipbl_pkg::S_SHIFT_RD;
            end
            ipbl_pkg::S_SCAN_RD:
                state_next = ipbl_pkg::S_SCAN_CMP;
            ipbl_pkg::S_SCAN_CMP:
            begin
                if ((addr_reg & rg_rdata[63:32]) == rg_rdata[31:0])
                begin
                    blk_next   = 1'b1;
                    src_next   = ipbl_pkg::SRC_RANGE;
                    state_next = ipbl_pkg::S_DONE;
                end
                else if (idx_reg + 1'b1 >= ECW'(rcnt_reg))
                    state_next = ipbl_pkg::S_DONE;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ipbl_pkg::S_SCAN_RD;
                end
            end
            ipbl_pkg::S_DONE:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                    state_next = ipbl_pkg::S_IDLE;
            end
            default: state_next = ipbl_pkg::S_IDLE;
        endcase
    end

    assign rsp.blocked         = blk_reg;
    assign rsp.match_source    = src_reg;
    assign rsp.status          = st_reg;
    assign rsp.exact_count_out = 9'(ecnt_reg);
    assign rsp.range_count_out = 5'(rcnt_reg);
endmodule
`default_nettype wire

// File: rtl/ipv4_blocklist_match_table.sv
// Top level: IPv4 blocklist match table
// One operation at a time. A lookup runs a binary search over the
// exact-address RAM, then, if no exact entry matched, scans the range
// entries one by one. Add and remove move entries one at a time through
// the single RAM port pair to open or close a slot. Add range writes one
// range entry unless the range table is full, and clear resets both counts.
// Each result waits in the output register until it is taken; the next request is accepted after that.
`default_nettype none
module ipv4_blocklist_match_table #(
    parameter int unsigned EXACT_DEPTH = ipbl_pkg::EXACT_DEPTH_DEF,
    parameter int unsigned RANGE_DEPTH = ipbl_pkg::RANGE_DEPTH_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    ipbl_req_if.sink   req,
    ipbl_rsp_if.source rsp
);
    localparam int unsigned EAW = (EXACT_DEPTH > 1) ? $clog2(EXACT_DEPTH) : 1;
    localparam int unsigned RAW = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;

    logic           ex_we, rg_we;
    logic [EAW-1:0] ex_waddr, ex_raddr;
    logic [31:0]    ex_wdata, ex_rdata;
    logic [RAW-1:0] rg_waddr, rg_raddr;
    logic [63:0]    rg_wdata, rg_rdata;

    ipbl_ctrl #(.EXACT_DEPTH(EXACT_DEPTH), .RANGE_DEPTH(RANGE_DEPTH)) u_ctrl (
        .clk, .rst_n, .req, .rsp,
        .ex_we, .ex_waddr, .ex_wdata, .ex_raddr, .ex_rdata,
        .rg_we, .rg_waddr, .rg_wdata, .rg_raddr, .rg_rdata
    );

    ipbl_ram #(.WIDTH(32), .DEPTH(EXACT_DEPTH)) u_exact (
        .clk, .we(ex_we), .waddr(ex_waddr), .wdata(ex_wdata),
        .raddr(ex_raddr), .rdata(ex_rdata)
    );

    ipbl_ram #(.WIDTH(64), .DEPTH(RANGE_DEPTH)) u_range (
        .clk, .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
        .raddr(rg_raddr), .rdata(rg_rdata)
    );
endmodule
`default_nettype wire
